>>> hdl/bt_pkg.sv
// shared types, constants and helpers for the binary trie prefix match block
// no dependencies; imported by bt_walk_ctrl, the top level and the testbench
`default_nettype none

package bt_pkg;

    // trie sizing
    localparam int NODE_COUNT = 1024;
    localparam int PORT_BITS  = 8;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int NODE_W     = 1 + PORT_BITS + 2 * IDX_W;

    // address walk
    localparam int ADDR_TOP = 31;
    localparam logic [5:0] LEVEL_MAX = 6'd32;

    // node count limit and first free node after the root
    localparam logic [FREE_W-1:0] NODE_LIMIT = FREE_W'(NODE_COUNT);
    localparam logic [FREE_W-1:0] FIRST_FREE = FREE_W'(1);

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [PORT_BITS-1:0] t_port;

    // one trie node as stored in the node memory
    typedef struct packed {
        logic                 matched;
        t_port                port;
        logic [1:0][IDX_W-1:0] kid;
    } t_node;

    // input beat
    typedef struct packed {
        logic        func;
        logic [31:0] ip_address;
        logic [5:0]  prefix_length;
        logic [7:0]  route_port;
    } t_in;

    // result beat
    typedef struct packed {
        logic       match_found;
        logic [7:0] match_port;
        logic [1:0] status;
    } t_out;

    // node memory access from the walker
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_node wdata;
        logic  re;
        t_idx  raddr;
    } t_mem_req;

    // finished operation from the walker
    typedef struct packed {
        logic valid;
        t_out result;
    } t_done;

    // stored port to the 8-bit result field
    function automatic logic [7:0] to_out_port(t_port p);
        logic [PORT_BITS+7:0] w;
        w = {8'd0, p};
        return w[7:0];
    endfunction

    // 8-bit route port to the stored width
    function automatic t_port to_node_port(logic [7:0] p);
        logic [PORT_BITS+7:0] w;
        w = {{PORT_BITS{1'b0}}, p};
        return w[PORT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/bt_node_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read data, valid in the cycle after the read; no dependencies
`default_nettype none

module bt_node_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 29,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/bt_walk_ctrl.sv
// trie walker: one level per cycle, reads, modifies and writes back nodes
// depends on bt_pkg; drives the node memory request of bt_node_ram
`default_nettype none

module bt_walk_ctrl
    import bt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in      i_item,
    output logic          o_busy,
    output t_mem_req      o_mem_req,
    input  wire t_node    i_rd_data,
    output t_done         o_done
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic              r_state, n_state;
    logic              r_func, n_func;
    logic [31:0]       r_ip, n_ip;
    logic [5:0]        r_len, n_len;
    t_port             r_port_in, n_port_in;
    logic [5:0]        r_level, n_level;
    t_idx              r_cur, n_cur;
    logic              r_use_zero, n_use_zero;
    logic              r_rd_root, n_rd_root;
    logic              r_root_valid, n_root_valid;
    logic [FREE_W-1:0] r_free, n_free;
    logic              r_found, n_found;
    t_port             r_mport, n_mport;

    t_node w_cur;
    t_node w_upd;
    logic  w_bit;
    t_idx  w_nxt;
    logic  w_missing;
    logic  w_full;
    logic  w_at_end;
    logic  w_bad_len;
    logic  w_found;
    t_port w_mport;

    // current node: fresh allocation or unwritten root read as cleared
    always_comb begin
        if (r_use_zero || (r_rd_root && !r_root_valid)) begin
            w_cur = '0;
        end else begin
            w_cur = i_rd_data;
        end
    end

    // level decode
    assign w_bit     = r_ip[ADDR_TOP];
    assign w_nxt     = w_cur.kid[w_bit];
    assign w_missing = (w_nxt == '0) || (FREE_W'(w_nxt) >= NODE_LIMIT);
    assign w_full    = r_free >= NODE_LIMIT;
    assign w_at_end  = (r_func == FUNC_INSERT) ? (r_level == r_len) : (r_level == LEVEL_MAX);
    assign w_bad_len = (i_item.prefix_length == 6'd0) || (i_item.prefix_length > LEVEL_MAX);
    assign w_found   = r_found | w_cur.matched;
    assign w_mport   = w_cur.matched ? w_cur.port : r_mport;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_ip         = r_ip;
        n_len        = r_len;
        n_port_in    = r_port_in;
        n_level      = r_level;
        n_cur        = r_cur;
        n_use_zero   = r_use_zero;
        n_rd_root    = r_rd_root;
        n_root_valid = r_root_valid;
        n_free       = r_free;
        n_found      = r_found;
        n_mport      = r_mport;
        w_upd        = w_cur;
        o_mem_req    = '0;
        o_done       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.func == FUNC_INSERT && w_bad_len) begin
                        // rejected insert answers at once
                        o_done.valid         = 1'b1;
                        o_done.result.status = STATUS_BAD_LEN;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = '0;
                        n_rd_root       = 1'b1;
                        n_state         = S_WALK;
                        n_func          = i_item.func;
                        n_ip            = i_item.ip_address;
                        n_len           = i_item.prefix_length;
                        n_port_in       = to_node_port(i_item.route_port);
                        n_level         = '0;
                        n_cur           = '0;
                        n_use_zero      = 1'b0;
                        n_found         = 1'b0;
                        n_mport         = '0;
                    end
                end
            end
            S_WALK: begin
                if (r_func == FUNC_INSERT) begin
                    o_mem_req.waddr = r_cur;
                    if (w_at_end) begin
                        // mark the prefix node and store its port
                        w_upd.matched        = 1'b1;
                        w_upd.port           = r_port_in;
                        o_mem_req.we         = 1'b1;
                        o_mem_req.wdata      = w_upd;
                        o_done.valid         = 1'b1;
                        o_done.result.status = STATUS_OK;
                        n_state              = S_IDLE;
                    end else if (w_missing && w_full) begin
                        // pool empty: keep what was built so far
                        o_mem_req.we         = 1'b1;
                        o_mem_req.wdata      = w_cur;
                        o_done.valid         = 1'b1;
                        o_done.result.status = STATUS_FULL;
                        n_state              = S_IDLE;
                    end else if (w_missing) begin
                        // link a fresh node and continue on it without a read
                        w_upd.kid[w_bit] = r_free[IDX_W-1:0];
                        o_mem_req.we     = 1'b1;
                        o_mem_req.wdata  = w_upd;
                        n_cur            = r_free[IDX_W-1:0];
                        n_free           = r_free + FREE_W'(1);
                        n_use_zero       = 1'b1;
                        n_rd_root        = 1'b0;
                        n_level          = r_level + 6'd1;
                        n_ip             = {r_ip[30:0], 1'b0};
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = w_nxt;
                        n_rd_root       = 1'b0;
                        n_cur           = w_nxt;
                        n_use_zero      = 1'b0;
                        n_level         = r_level + 6'd1;
                        n_ip            = {r_ip[30:0], 1'b0};
                    end
                end else begin
                    n_found = w_found;
                    n_mport = w_mport;
                    if (w_at_end || w_missing) begin
                        o_done.valid              = 1'b1;
                        o_done.result.match_found = w_found;
                        o_done.result.match_port  = to_out_port(w_mport);
                        o_done.result.status      = STATUS_OK;
                        n_state                   = S_IDLE;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = w_nxt;
                        n_rd_root       = 1'b0;
                        n_cur           = w_nxt;
                        n_use_zero      = 1'b0;
                        n_level         = r_level + 6'd1;
                        n_ip            = {r_ip[30:0], 1'b0};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the root holds real data once written
        if (o_mem_req.we && o_mem_req.waddr == '0) begin
            n_root_valid = 1'b1;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_root_valid <= 1'b0;
            r_free       <= FIRST_FREE;
        end else begin
            r_state      <= n_state;
            r_root_valid <= n_root_valid;
            r_free       <= n_free;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_ip       <= n_ip;
        r_len      <= n_len;
        r_port_in  <= n_port_in;
        r_level    <= n_level;
        r_cur      <= n_cur;
        r_use_zero <= n_use_zero;
        r_rd_root  <= n_rd_root;
        r_found    <= n_found;
        r_mport    <= n_mport;
    end

    // a new operation only starts from idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("walker started while busy");

    // a level never both writes and reads the node memory
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("node memory read and write in one cycle");

    // the allocation counter never passes the pool size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free >= FIRST_FREE) && (r_free <= NODE_LIMIT))
        else $error("allocation counter out of range");

    // an allocation continues on the fresh node with cleared contents
    a_alloc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && o_mem_req.we && !o_done.valid) |=>
            (r_use_zero && r_state == S_WALK && r_free == $past(r_free) + FREE_W'(1)))
        else $error("allocation did not advance onto fresh node");

endmodule

`default_nettype wire

>>> hdl/binary_trie_prefix_match_top.sv
// top level of the binary trie prefix match block: handshakes and result register
// depends on bt_pkg, bt_node_ram and bt_walk_ctrl
`default_nettype none

// Longest-prefix match over a unibit trie of IPv4 routes held in a node memory of
// NODE_COUNT entries. One beat on the input is one insert or one lookup, and each
// gives exactly one result beat. Operations run one at a time: the walker visits one
// trie level per cycle, bounded by the registered read of the node memory. An insert
// walks one level per bit of its prefix length, a lookup until a child is missing or
// all 32 address bits are used, and an insert with a bad prefix length has its result
// registered in the cycle after the accept. The next beat is taken only while the
// walker is idle and the result register is empty or being drained in that cycle, so
// a stalled consumer holds off the input. Reset empties the table at once: the root is
// tracked by a flag and other nodes are written on allocation, so there is no clearing pass.

module binary_trie_prefix_match_top
    import bt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic     w_busy;
    logic     w_start;
    t_mem_req w_mem_req;
    t_done    w_done;
    t_node    w_rd_data;
    logic     r_out_valid;
    t_out     r_out_data;

    // accept while idle and the result slot is free or being drained
    assign o_in_ready = !w_busy && (!r_out_valid || i_out_ready);
    assign w_start    = i_in_valid && o_in_ready;

    bt_node_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (NODE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.we),
        .i_waddr (w_mem_req.waddr),
        .i_wdata (w_mem_req.wdata),
        .i_re    (w_mem_req.re),
        .i_raddr (w_mem_req.raddr),
        .o_rdata (w_rd_data)
    );

    bt_walk_ctrl u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_item    (i_in_data),
        .o_busy    (w_busy),
        .o_mem_req (w_mem_req),
        .i_rd_data (w_rd_data),
        .o_done    (w_done)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done.valid) begin
            r_out_data <= w_done.result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a finished operation never lands on an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done.valid |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

    // no input beat is taken while a walk is in progress
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_in_ready)
        else $error("input accepted during walk");

    // a failed insert never reports a match
    a_insert_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done.valid && w_done.result.status != STATUS_OK) |->
            (!w_done.result.match_found && w_done.result.match_port == 8'd0))
        else $error("failed insert reported a match");

endmodule

`default_nettype wire

>>> verif/tb_binary_trie_prefix_match_top.sv
// testbench for binary_trie_prefix_match_top: directed and random route inserts and
// address lookups, checked against a trie kept in a small scoreboard class
// depends on bt_pkg and the block's rtl

module tb_binary_trie_prefix_match_top;
    import bt_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int CLK_PERIOD       = 2 * CLK_HALF;
    localparam int RESET_CYCLES     = 3;
    localparam int POOL_SIZE        = 16;
    localparam int MAIN_OPS         = 1100;
    localparam int TAIL_OPS         = 200;
    localparam int HOLD_OPS         = 12;
    localparam int RX_HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RUN_LIMIT_CYCLES = 600000;
    localparam int REPORT_MAX       = 10;

    typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    // trie of routes plus the queue of answers still owed by the block
    class route_trie_sb;
        bit          matched[NODE_COUNT];
        t_port       node_port[NODE_COUNT];
        int unsigned kid_zero[NODE_COUNT];
        int unsigned kid_one[NODE_COUNT];
        int unsigned free_node;
        t_out        answers[$];
        int          mismatches;

        function new();
            for (int n = 0; n < NODE_COUNT; n++) begin
                matched[n]   = 1'b0;
                node_port[n] = '0;
                kid_zero[n]  = 0;
                kid_one[n]   = 0;
            end
            free_node  = 1;
            mismatches = 0;
        endfunction

        // walk len levels, allocating missing nodes, then mark the last one
        function logic [1:0] add_route(logic [31:0] ip, logic [5:0] len, logic [7:0] p);
            int unsigned cur;
            int unsigned nxt;
            int          lvl;
            bit          b;
            cur = 0;
            if (len == 0 || len > LEVEL_MAX) return STATUS_BAD_LEN;
            for (lvl = 0; lvl < len; lvl++) begin
                b = ip[ADDR_TOP - lvl];
                nxt = b ? kid_one[cur] : kid_zero[cur];
                if (nxt == 0) begin
                    if (free_node >= NODE_COUNT) return STATUS_FULL;
                    nxt = free_node;
                    free_node++;
                    matched[nxt]   = 1'b0;
                    node_port[nxt] = '0;
                    kid_zero[nxt]  = 0;
                    kid_one[nxt]   = 0;
                    if (b) kid_one[cur] = nxt;
                    else kid_zero[cur] = nxt;
                end
                cur = nxt;
            end
            matched[cur]   = 1'b1;
            node_port[cur] = t_port'(p);
            return STATUS_OK;
        endfunction

        // deepest matched node along the address path
        function t_out find_route(logic [31:0] ip);
            t_out        r;
            int unsigned cur;
            int          lvl;
            r = '0;
            r.status = STATUS_OK;
            cur = 0;
            for (lvl = 0; lvl <= ADDR_TOP + 1; lvl++) begin
                if (matched[cur]) begin
                    r.match_found = 1'b1;
                    r.match_port  = 8'(node_port[cur]);
                end
                if (lvl > ADDR_TOP) break;
                cur = ip[ADDR_TOP - lvl] ? kid_one[cur] : kid_zero[cur];
                if (cur == 0) break;
            end
            return r;
        endfunction

        // accepted input beat: update the trie and queue the answer it owes
        function void note_op(t_in op);
            t_out r;
            if (op.func == FUNC_INSERT) begin
                r = '0;
                r.status = add_route(op.ip_address, op.prefix_length, op.route_port);
            end else begin
                r = find_route(op.ip_address);
            end
            answers.push_back(r);
        endfunction

        // accepted result beat against the oldest owed answer
        function void check_answer(t_out got);
            t_out want;
            if (answers.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: found=%0d port=%02h status=%0d",
                             got.match_found, got.match_port, got.status);
                return;
            end
            want = answers.pop_front();
            if (got.match_found !== want.match_found || got.match_port !== want.match_port ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: want found=%0d port=%02h status=%0d, got found=%0d port=%02h status=%0d",
                             want.match_found, want.match_port, want.status,
                             got.match_found, got.match_port, got.status);
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    bit           rx_hold_req = 1'b0;
    logic [31:0]  route_base[POOL_SIZE];
    int           burst_left  = 0;
    route_trie_sb trie;

    binary_trie_prefix_match_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            trie.check_answer(o_out_data);
        end
    end

    // receiver stalls in segments of random style, plus one long hold-off on request
    initial begin : rx_pattern
        int       seg_left;
        int       k;
        rx_mode_e mode;
        seg_left = 0;
        mode = RX_FREE;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                for (k = 1; k < RX_HOLD_CYCLES; k++) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    RX_FREE:   i_out_ready <= 1'b1;
                    RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    // run limit
    initial begin : run_limit
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_in mk_op(logic f, logic [31:0] ip, logic [5:0] len, logic [7:0] p);
        t_in op;
        op.func          = f;
        op.ip_address    = ip;
        op.prefix_length = len;
        op.route_port    = p;
        return op;
    endfunction

    // pool address with the top split bits kept and the rest random
    function automatic logic [31:0] near_base(int split);
        logic [31:0] keep;
        keep = ~(32'hFFFF_FFFF >> split);
        return (route_base[$urandom_range(0, POOL_SIZE - 1)] & keep) | ($urandom & ~keep);
    endfunction

    // mostly routes along the pool paths, some short random ones, some bad lengths
    function automatic t_in rand_insert();
        logic [5:0] len;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            len = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
            return mk_op(FUNC_INSERT, $urandom, len, 8'($urandom));
        end
        if (pick < 16) begin
            len = 6'($urandom_range(1, 8));
            return mk_op(FUNC_INSERT, $urandom, len, 8'($urandom));
        end
        len = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(25, 32)) : 6'($urandom_range(1, 24));
        return mk_op(FUNC_INSERT, near_base(len), len, 8'($urandom));
    endfunction

    // lookups near the pool paths; length and port fields are noise
    function automatic t_in rand_lookup();
        logic [31:0] ip;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) ip = route_base[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 85) ip = near_base($urandom_range(0, 32));
        else ip = $urandom;
        return mk_op(FUNC_LOOKUP, ip, 6'($urandom), 8'($urandom));
    endfunction

    function automatic t_in rand_op();
        if ($urandom_range(0, 99) < 45) return rand_insert();
        return rand_lookup();
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_op(input t_in op);
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        trie.note_op(op);
    endtask

    // one beat inside a burst; a gap may follow the end of a burst
    task automatic issue(input t_in op);
        int gap;
        send_op(op);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering until every owed answer has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (trie.answers.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int i;
        trie = new();
        foreach (route_base[k]) route_base[k] = $urandom;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, bad lengths, extremes of address and port
        issue(mk_op(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'h00));
        issue(mk_op(FUNC_INSERT, 32'h1234_5678, 6'd0,  8'h44));
        issue(mk_op(FUNC_INSERT, 32'h8765_4321, 6'd33, 8'h01));
        issue(mk_op(FUNC_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF));
        issue(mk_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF));
        issue(mk_op(FUNC_INSERT, 32'h8000_0000, 6'd1,  8'h11));
        issue(mk_op(FUNC_INSERT, 32'h0000_0000, 6'd1,  8'h00));
        issue(mk_op(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF));
        issue(mk_op(FUNC_INSERT, 32'h0A00_0000, 6'd8,  8'h0A));
        issue(mk_op(FUNC_INSERT, 32'h0A01_0000, 6'd16, 8'h5A));
        issue(mk_op(FUNC_LOOKUP, 32'h0A01_0203, 6'd0,  8'h00));
        issue(mk_op(FUNC_LOOKUP, 32'h0A02_0304, 6'd0,  8'h00));
        issue(mk_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00));
        issue(mk_op(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0,  8'h00));
        issue(mk_op(FUNC_LOOKUP, 32'h7FFF_FFFF, 6'd0,  8'h00));
        // re-insert overwrites the port
        issue(mk_op(FUNC_INSERT, 32'h0A00_0000, 6'd8,  8'hC3));
        issue(mk_op(FUNC_LOOKUP, 32'h0A7F_0000, 6'd0,  8'h00));
        issue(mk_op(FUNC_INSERT, 32'h0000_0000, 6'd32, 8'h55));
        issue(mk_op(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'h00));
        issue(mk_op(FUNC_LOOKUP, 32'h0000_0001, 6'd0,  8'h00));
        issue(mk_op(FUNC_INSERT, 32'hAAAA_AAAA, 6'd32, 8'hA5));
        issue(mk_op(FUNC_LOOKUP, 32'hAAAA_AAAA, 6'd63, 8'hFF));
        issue(mk_op(FUNC_LOOKUP, 32'h5555_5555, 6'd63, 8'hFF));
        drain_results();

        // random mix with one long receiver hold-off and two full drains
        for (i = 0; i < MAIN_OPS; i++) begin
            if (i == 300 || i == 800) drain_results();
            if (i == 500) begin
                rx_hold_req = 1'b1;
                for (int h = 0; h < HOLD_OPS; h++) send_op(rand_op());
            end
            issue(rand_op());
        end

        // full-length random routes until the node pool runs out
        while (trie.free_node < NODE_COUNT) begin
            if ($urandom_range(0, 2) == 0) issue(rand_lookup());
            else issue(mk_op(FUNC_INSERT, $urandom, 6'd32, 8'($urandom)));
        end

        // table full: new paths fail, existing paths still take updates
        for (i = 0; i < TAIL_OPS; i++) begin
            if ($urandom_range(0, 3) == 0)
                issue(mk_op(FUNC_INSERT, $urandom, 6'($urandom_range(1, 32)), 8'($urandom)));
            else
                issue(rand_op());
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (trie.mismatches == 0 && trie.answers.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bt_pkg.sv
hdl/bt_node_ram.sv
hdl/bt_walk_ctrl.sv
hdl/binary_trie_prefix_match_top.sv
verif/tb_binary_trie_prefix_match_top.sv
